[design/dpf_pkg.sv]
package dpf_pkg;

  localparam int DEPTH_DEF   = 256;
  localparam int ID_W_DEF    = 16;
  localparam int TIME_W_DEF  = 32;
  localparam int LIMIT_W     = 9;
  localparam int COUNT_OUT_W = 9;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_FWD = 2'd1;
  localparam logic [1:0] OP_CNT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

endpackage

[design/dpf_if.sv]
interface dpf_req_if #(
  parameter int ID_W = 16,
  parameter int TIME_W = 32
);
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ID_W-1:0]   source_id;
  logic [ID_W-1:0]   dest_id;
  logic [TIME_W-1:0] time_stamp;
  logic [TIME_W-1:0] range_start;
  logic [TIME_W-1:0] range_end;

  modport source (output valid, opcode, source_id, dest_id, time_stamp, range_start,
                  range_end, input ready);
  modport sink (input valid, opcode, source_id, dest_id, time_stamp, range_start,
                range_end, output ready);
endinterface

interface dpf_rsp_if #(
  parameter int ID_W = 16,
  parameter int TIME_W = 32
);
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              found;
  logic [ID_W-1:0]   out_source;
  logic [ID_W-1:0]   out_destination;
  logic [TIME_W-1:0] out_time;
  logic [8:0]        match_count;

  modport source (output valid, accepted, found, out_source, out_destination, out_time,
                  match_count, input ready);
  modport sink (input valid, accepted, found, out_source, out_destination, out_time,
                match_count, output ready);
endinterface

[design/dpf_cell.sv]
module dpf_cell #(
  parameter int IDX = 0,
  parameter int ID_W = 16,
  parameter int TIME_W = 32,
  parameter int OW = 9,
  parameter int AW = 8,
  parameter int CW = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  dpf_pkg::cell_ctl_t ctl,
  input  logic [AW-1:0]      wr_idx,
  input  logic [OW-1:0]      occ,
  input  logic [ID_W-1:0]    wr_src,
  input  logic [ID_W-1:0]    wr_dst,
  input  logic [TIME_W-1:0]  wr_time,
  input  logic [ID_W-1:0]    nb_src,
  input  logic [ID_W-1:0]    nb_dst,
  input  logic [TIME_W-1:0]  nb_time,
  input  logic [ID_W-1:0]    q_src,
  input  logic [ID_W-1:0]    q_dst,
  input  logic [TIME_W-1:0]  q_time,
  input  logic [TIME_W-1:0]  q_lo,
  input  logic [TIME_W-1:0]  q_hi,
  input  logic               vld_in,
  input  logic               dup_in,
  input  logic [CW-1:0]      cnt_in,
  output logic [ID_W-1:0]    e_src,
  output logic [ID_W-1:0]    e_dst,
  output logic [TIME_W-1:0]  e_time,
  output logic               vld_out,
  output logic               dup_out,
  output logic [CW-1:0]      cnt_out
);
  import dpf_pkg::*;

  logic live, hit_dup, hit_cnt;

  assign live    = OW'(IDX) < occ;
  assign hit_dup = live && (e_src == q_src) && (e_dst == q_dst) && (e_time == q_time);
  assign hit_cnt = live && (e_dst == q_dst) && (e_time >= q_lo) && (e_time <= q_hi);

  always_ff @(posedge clk) begin
    if (ctl.wr && (wr_idx == AW'(IDX))) begin
      e_src  <= wr_src;
      e_dst  <= wr_dst;
      e_time <= wr_time;
    end else if (ctl.shift) begin
      e_src  <= nb_src;
      e_dst  <= nb_dst;
      e_time <= nb_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
    dup_out <= dup_in | hit_dup;
    cnt_out <= cnt_in + CW'(hit_cnt);
  end

endmodule

[design/dedup_packet_fifo_with_range_count_unit.sv]
// Forward and unused opcodes: the result word is valid in the cycle after accept.
// Add and count: a start register launches the query, which passes once through the
// DEPTH-cell chain, one cell per cycle; the result word follows as it leaves the chain.
// One operation in flight; the next word is taken once the result is taken.
// Synchronous active-high reset empties the buffer and sets the limit to 256.
module dedup_packet_fifo_with_range_count_unit #(
  parameter int DEPTH = dpf_pkg::DEPTH_DEF,
  parameter int ID_W = dpf_pkg::ID_W_DEF,
  parameter int TIME_W = dpf_pkg::TIME_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dpf_pkg::LIMIT_W-1:0]  cfg_wdata,
  dpf_req_if.sink                      req,
  dpf_rsp_if.source                    rsp
);
  import dpf_pkg::*;

  localparam int OW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = LIMIT_W + OW;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  state_t state, state_next;
  logic [LIMIT_W-1:0] limit;
  logic [OW-1:0] occ, occ_next, lim_eff;
  logic [XW-1:0] limit_x;
  logic [1:0] op;
  logic [ID_W-1:0] q_src, q_dst;
  logic [TIME_W-1:0] q_time, q_lo, q_hi;
  logic start;
  cell_ctl_t ctl;
  logic [AW-1:0] wr_idx;
  logic acc_in, fwd_go, add_go, done, full_lim;
  logic [CW+COUNT_OUT_W-1:0] cnt_x;

  logic [ID_W-1:0]   e_src  [DEPTH+1];
  logic [ID_W-1:0]   e_dst  [DEPTH+1];
  logic [TIME_W-1:0] e_time [DEPTH+1];
  logic              q_vld  [DEPTH+1];
  logic              q_dup  [DEPTH+1];
  logic [CW-1:0]     q_cnt  [DEPTH+1];

  assign e_src[DEPTH]  = '0;
  assign e_dst[DEPTH]  = '0;
  assign e_time[DEPTH] = '0;
  assign q_vld[0] = start;
  assign q_dup[0] = 1'b0;
  assign q_cnt[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dpf_cell #(
      .IDX(i), .ID_W(ID_W), .TIME_W(TIME_W), .OW(OW), .AW(AW), .CW(CW)
    ) u_cell (
      .clk, .rst, .ctl, .wr_idx, .occ,
      .wr_src(q_src), .wr_dst(q_dst), .wr_time(q_time),
      .nb_src(e_src[i+1]), .nb_dst(e_dst[i+1]), .nb_time(e_time[i+1]),
      .q_src, .q_dst, .q_time, .q_lo, .q_hi,
      .vld_in(q_vld[i]), .dup_in(q_dup[i]), .cnt_in(q_cnt[i]),
      .e_src(e_src[i]), .e_dst(e_dst[i]), .e_time(e_time[i]),
      .vld_out(q_vld[i+1]), .dup_out(q_dup[i+1]), .cnt_out(q_cnt[i+1])
    );
  end

  assign limit_x = XW'(limit);
  always_comb begin
    priority if (limit == '0) begin
      lim_eff = OW'(1);
    end else if (limit_x > DEPTH_X) begin
      lim_eff = OW'(DEPTH);
    end else begin
      lim_eff = limit_x[OW-1:0];
    end
  end

  assign acc_in   = req.valid && req.ready;
  assign done     = (state == ST_SCAN) && q_vld[DEPTH];
  assign full_lim = occ >= lim_eff;
  assign fwd_go   = acc_in && (req.opcode == OP_FWD) && (occ != '0);
  assign add_go   = done && (op == OP_ADD) && !q_dup[DEPTH];
  assign cnt_x    = (CW+COUNT_OUT_W)'(q_cnt[DEPTH]);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc_in) begin
          state_next = (req.opcode == OP_ADD || req.opcode == OP_CNT) ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        if (done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (rsp.valid && rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    rsp.valid = (state == ST_OUT);
    ctl.shift = fwd_go || (add_go && full_lim);
    ctl.wr    = add_go;
    wr_idx    = full_lim ? AW'(occ - OW'(1)) : AW'(occ);
    occ_next  = occ;
    if (fwd_go) begin
      occ_next = occ - OW'(1);
    end else if (add_go && !full_lim) begin
      occ_next = occ + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occ   <= '0;
      limit <= LIMIT_RESET;
      start <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      start <= acc_in && (req.opcode == OP_ADD || req.opcode == OP_CNT);
      if (cfg_we) limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      op     <= req.opcode;
      q_src  <= req.source_id;
      q_dst  <= req.dest_id;
      q_time <= req.time_stamp;
      q_lo   <= req.range_start;
      q_hi   <= req.range_end;
      rsp.accepted        <= 1'b0;
      rsp.match_count     <= '0;
      rsp.found           <= fwd_go;
      rsp.out_source      <= fwd_go ? e_src[0] : '0;
      rsp.out_destination <= fwd_go ? e_dst[0] : '0;
      rsp.out_time        <= fwd_go ? e_time[0] : '0;
    end else if (done) begin
      rsp.accepted    <= add_go;
      rsp.match_count <= (op == OP_CNT) ? cnt_x[COUNT_OUT_W-1:0] : '0;
    end
  end

endmodule

[design/dpf_checker.sv]
module dpf_checker #(
  parameter int ID_W = 16
) (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            accepted,
  input logic            found,
  input logic [ID_W-1:0] out_source,
  input logic [8:0]      match_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before taken");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && found))
    else $error("add and forward flags both set");

  a_add_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (accepted || found) |-> match_count == '0)
    else $error("count nonzero on add or forward");

  a_nofwd: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> out_source == '0)
    else $error("source nonzero without forward");

endmodule

bind dedup_packet_fifo_with_range_count_unit dpf_checker #(.ID_W(ID_W)) u_dpf_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(req.ready),
  .out_valid(rsp.valid),
  .out_ready(rsp.ready),
  .accepted(rsp.accepted),
  .found(rsp.found),
  .out_source(rsp.out_source),
  .match_count(rsp.match_count)
);
